/* hdl/vpic_pkg.sv */
package vpic_pkg;

  localparam int unsigned SIZE_W    = 14;
  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned TS_W      = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TSP_CNT_W = 7;
  localparam int unsigned TSPW_W    = 8;
  localparam int unsigned RECIP_W   = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] MAX_PAYLOAD_BYTES = 14'd12032;
  localparam logic [SIZE_W-1:0] RTP_HDR_BYTES     = 14'd12;
  localparam logic [BYTE_W-1:0] RTP_KEEP_HDR      = 8'h10;

  localparam logic [TSPW_W-1:0] TSP_SIZE             = 8'd188;
  localparam logic [TSPW_W-1:0] TSP_SIZE_WITH_HEADER = 8'd192;

  // floor(2^16 / width): quotient estimate is exact or one short
  localparam logic [RECIP_W-1:0] RECIP_TSP     = 9'd348;
  localparam logic [RECIP_W-1:0] RECIP_TSP_HDR = 9'd341;
  localparam int unsigned        RECIP_SHIFT   = 16;

  // x / 3 for x < 256 as (x * 171) >> 9
  localparam logic [7:0]  DIV3_RECIP = 8'd171;
  localparam int unsigned DIV3_SHIFT = 9;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_MULT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STREAM_FORMAT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_SIZE = 1'd1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;

  typedef struct packed {
    logic                 stream_format;
    logic [SIZE_W-1:0]    max_packet_size;
    logic [TSP_CNT_W-1:0] max_tsps;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 is_iec;
    logic                 sph;
    logic [SEQ_W-1:0]     seq;
    logic [TS_W-1:0]      ts;
    logic [BYTE_W-1:0]    mpt;
    logic                 serr;
    logic [SIZE_W-1:0]    start_off;
    logic [SIZE_W-1:0]    end_off;
    logic [TSP_CNT_W-1:0] tsps;
    logic [TSP_CNT_W-1:0] max_tsps;
    logic [SIZE_W-1:0]    chunk_bytes;
  } cmd_t;

endpackage

/* hdl/vpic_front.sv */
module vpic_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vpic_pkg::SIZE_W-1:0]    packet_size,
  input  logic                           sph_present,
  input  logic [vpic_pkg::BYTE_W-1:0]    rtp_first_byte,
  input  logic [vpic_pkg::BYTE_W-1:0]    rtp_second_byte,
  input  logic [vpic_pkg::SEQ_W-1:0]     rtp_sequence,
  input  logic [vpic_pkg::TS_W-1:0]      rtp_timestamp,
  input  vpic_pkg::cfg_t                 cfg,
  output logic                           push,
  output vpic_pkg::cmd_t                 push_cmd,
  input  logic                           push_ready
);
  import vpic_pkg::*;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_EST   = 3'd1;
  localparam logic [2:0] F_FIX   = 3'd2;
  localparam logic [2:0] F_SCALE = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0]           state;
  logic [SIZE_W-1:0]    size_r;
  logic                 sph_r;
  logic                 keep_r;
  logic [BYTE_W-1:0]    mpt_r;
  logic [SEQ_W-1:0]     seq_r;
  logic [TS_W-1:0]      ts_r;
  logic [TSP_CNT_W-1:0] q_est;
  logic [TSP_CNT_W-1:0] tsps;
  logic                 rem_nz;
  logic [SIZE_W-1:0]    chunk_bytes;
  logic [SEQ_W-1:0]     last_sequence;

  logic [TSPW_W-1:0]           tsp_width;
  logic [RECIP_W-1:0]          recip;
  logic [SIZE_W+RECIP_W-1:0]   prod_est;
  logic [SIZE_W:0]             prod_back;
  logic [SIZE_W:0]             diff;
  logic [TSPW_W:0]             rem;
  logic [TSPW_W:0]             rem_adj;
  logic [SIZE_W-1:0]           chunk_prod;
  logic                        drop;
  logic                        seq_take;
  logic                        serr;
  cmd_t                        cmd;

  assign tsp_width = sph_r ? TSP_SIZE_WITH_HEADER : TSP_SIZE;
  assign recip     = sph_r ? RECIP_TSP_HDR : RECIP_TSP;
  assign prod_est  = {{RECIP_W{1'b0}}, size_r} * {{SIZE_W{1'b0}}, recip};
  assign prod_back = {{(SIZE_W+1-TSP_CNT_W){1'b0}}, q_est}
                   * {{(SIZE_W+1-TSPW_W){1'b0}}, tsp_width};
  assign diff      = {1'b0, size_r} - prod_back;
  assign rem       = diff[TSPW_W:0];
  assign rem_adj   = rem - {1'b0, tsp_width};
  assign chunk_prod = {{(SIZE_W-TSP_CNT_W){1'b0}}, cfg.max_tsps}
                    * {{(SIZE_W-TSPW_W){1'b0}}, tsp_width};
  assign serr = (last_sequence != '0) && (seq_r != last_sequence + 16'd1);

  assign in_ready = (state == F_IDLE);

  // sort the item into one command for the back end, or drop it
  always_comb begin
    cmd      = '0;
    drop     = 1'b0;
    seq_take = 1'b0;
    cmd.is_iec = cfg.stream_format;
    if (!cfg.stream_format) begin
      priority if (size_r > cfg.max_packet_size || size_r > MAX_PAYLOAD_BYTES) begin
        cmd.status = ST_TOO_LARGE;
      end else if (size_r < RTP_HDR_BYTES) begin
        cmd.status = ST_SHORT;
      end else begin
        cmd.status    = ST_OK;
        cmd.start_off = keep_r ? '0 : RTP_HDR_BYTES;
        cmd.end_off   = size_r;
        cmd.seq       = seq_r;
        cmd.ts        = ts_r;
        cmd.mpt       = mpt_r;
        cmd.serr      = serr;
        seq_take      = 1'b1;
      end
    end else begin
      priority if (size_r > MAX_PAYLOAD_BYTES) begin
        cmd.status = ST_TOO_LARGE;
      end else if (rem_nz) begin
        cmd.status = ST_NOT_MULT;
      end else if (size_r == '0) begin
        drop = 1'b1;
      end else begin
        cmd.status      = ST_OK;
        cmd.sph         = sph_r;
        cmd.end_off     = size_r;
        cmd.tsps        = tsps;
        cmd.max_tsps    = cfg.max_tsps;
        cmd.chunk_bytes = chunk_bytes;
      end
    end
  end

  assign push     = (state == F_PUSH) && !drop;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      last_sequence <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_EST;
          end
        end
        F_EST:   state <= F_FIX;
        F_FIX:   state <= F_SCALE;
        F_SCALE: state <= F_PUSH;
        F_PUSH: begin
          if (drop) begin
            state <= F_IDLE;
          end else if (push_ready) begin
            state <= F_IDLE;
            if (seq_take) begin
              last_sequence <= seq_r;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      size_r <= packet_size;
      sph_r  <= sph_present;
      keep_r <= (rtp_first_byte & RTP_KEEP_HDR) != '0;
      mpt_r  <= rtp_second_byte;
      seq_r  <= rtp_sequence;
      ts_r   <= rtp_timestamp;
    end
    if (state == F_EST) begin
      q_est <= prod_est[RECIP_SHIFT +: TSP_CNT_W];
    end
    if (state == F_FIX) begin
      if (rem >= {1'b0, tsp_width}) begin
        tsps   <= q_est + 7'd1;
        rem_nz <= rem_adj != '0;
      end else begin
        tsps   <= q_est;
        rem_nz <= rem != '0;
      end
    end
    if (state == F_SCALE) begin
      chunk_bytes <= chunk_prod;
    end
  end

endmodule

/* hdl/vpic_queue.sv */
module vpic_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  vpic_pkg::cmd_t wr_cmd,
  output logic           wr_ready,
  output logic           rd_valid,
  output vpic_pkg::cmd_t rd_cmd,
  input  logic           rd_en
);
  import vpic_pkg::*;

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_wr;
  logic                   do_rd;

  assign wr_ready = (count != QUEUE_PTR_W'(0) + (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

/* hdl/vpic_back.sv */
module vpic_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  vpic_pkg::cmd_t                cmd_in,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vpic_pkg::STATUS_W-1:0] status,
  output logic [vpic_pkg::SIZE_W-1:0]   chunk_offset,
  output logic [vpic_pkg::SIZE_W-1:0]   chunk_size,
  output logic                          has_sph,
  output logic                          is_iec,
  output logic [vpic_pkg::SEQ_W-1:0]    sequence_number,
  output logic [vpic_pkg::TS_W-1:0]     timestamp_out,
  output logic [vpic_pkg::BYTE_W-1:0]   marker_payload_type,
  output logic                          sequence_error,
  output logic                          last
);
  import vpic_pkg::*;

  logic                 busy;
  cmd_t                 cur;
  logic [SIZE_W-1:0]    off;
  logic [TSP_CNT_W-1:0] rem_tsps;
  logic                 emit;
  logic                 split;

  assign cmd_pop = cmd_valid && !busy;
  assign emit    = busy && (!out_valid || out_ready);
  // full-size chunk while a chunk limit is set and more than one chunk's worth remains
  assign split   = (cur.max_tsps != '0) && (rem_tsps > cur.max_tsps);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        busy <= 1'b1;
      end else if (emit && !split) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur      <= cmd_in;
      off      <= cmd_in.start_off;
      rem_tsps <= cmd_in.tsps;
    end else if (emit && split) begin
      off      <= off + cur.chunk_bytes;
      rem_tsps <= rem_tsps - cur.max_tsps;
    end
    if (emit) begin
      status              <= cur.status;
      chunk_offset        <= off;
      chunk_size          <= split ? cur.chunk_bytes : cur.end_off - off;
      has_sph             <= cur.sph;
      is_iec              <= cur.is_iec;
      sequence_number     <= cur.seq;
      timestamp_out       <= cur.ts;
      marker_payload_type <= cur.mpt;
      sequence_error      <= cur.serr;
      last                <= !split;
    end
  end

endmodule

/* hdl/video_packet_ingest_chunker.sv */
// Video packet ingest chunker. Each input item describes one received video
// packet. With stream_format 0 (RTP H.264) the item yields exactly one result:
// a reject (too large, or shorter than the 12-byte RTP header) or the payload
// range with the header stripped unless bit 0x10 of byte 0 is set, plus the
// sequence number, timestamp, byte 1 and a gap flag against the last good
// sequence number. With stream_format 1 (MPEG-TS) the size must be a whole
// number of 188-byte (or 192-byte with source headers) transport packets; the
// payload is then cut into chunks of max_packet_size/192 transport packets and
// a final remainder chunk, and an empty payload gives no result at all. The
// last flag marks the final result of each item. A front sequencer steps an
// item through accept, quotient estimate and correction, chunk scaling and
// hand-off (held while the queue is full) before the next; a two-entry command
// queue decouples it from the back end, which registers an item's results one
// per cycle while out_ready holds, so new items enter while results wait.
// Write the configuration registers only while no item is in flight.
module video_packet_ingest_chunker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [vpic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vpic_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vpic_pkg::SIZE_W-1:0]    packet_size,
  input  logic                           sph_present,
  input  logic [vpic_pkg::BYTE_W-1:0]    rtp_first_byte,
  input  logic [vpic_pkg::BYTE_W-1:0]    rtp_second_byte,
  input  logic [vpic_pkg::SEQ_W-1:0]     rtp_sequence,
  input  logic [vpic_pkg::TS_W-1:0]      rtp_timestamp,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vpic_pkg::STATUS_W-1:0]  status,
  output logic [vpic_pkg::SIZE_W-1:0]    chunk_offset,
  output logic [vpic_pkg::SIZE_W-1:0]    chunk_size,
  output logic                           has_sph,
  output logic                           is_iec,
  output logic [vpic_pkg::SEQ_W-1:0]     sequence_number,
  output logic [vpic_pkg::TS_W-1:0]      timestamp_out,
  output logic [vpic_pkg::BYTE_W-1:0]    marker_payload_type,
  output logic                           sequence_error,
  output logic                           last
);
  import vpic_pkg::*;

  logic              stream_format;
  logic [SIZE_W-1:0] max_packet_size;
  logic [TSP_CNT_W-1:0] max_tsps;
  logic [15:0]       div3_prod;
  cfg_t              cfg;

  logic q_push;
  logic q_push_ready;
  logic q_valid;
  logic q_pop;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;

  // hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_format   <= 1'b0;
      max_packet_size <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STREAM_FORMAT:   stream_format   <= cfg_data[0];
        REG_MAX_PACKET_SIZE: max_packet_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // transport packets per chunk: max_packet_size / 192 = (size >> 6) / 3;
  // registered in max_tsps behind max_packet_size, before the front end needs it
  assign div3_prod = {8'b0, max_packet_size[SIZE_W-1:6]} * {8'b0, DIV3_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tsps <= '0;
    end else begin
      max_tsps <= div3_prod[DIV3_SHIFT +: TSP_CNT_W];
    end
  end

  assign cfg.stream_format   = stream_format;
  assign cfg.max_packet_size = max_packet_size;
  assign cfg.max_tsps        = max_tsps;

  vpic_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .packet_size     (packet_size),
    .sph_present     (sph_present),
    .rtp_first_byte  (rtp_first_byte),
    .rtp_second_byte (rtp_second_byte),
    .rtp_sequence    (rtp_sequence),
    .rtp_timestamp   (rtp_timestamp),
    .cfg             (cfg),
    .push            (q_push),
    .push_cmd        (q_wr_cmd),
    .push_ready      (q_push_ready)
  );

  vpic_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_cmd   (q_wr_cmd),
    .wr_ready (q_push_ready),
    .rd_valid (q_valid),
    .rd_cmd   (q_rd_cmd),
    .rd_en    (q_pop)
  );

  vpic_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cmd_valid           (q_valid),
    .cmd_in              (q_rd_cmd),
    .cmd_pop             (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .chunk_offset        (chunk_offset),
    .chunk_size          (chunk_size),
    .has_sph             (has_sph),
    .is_iec              (is_iec),
    .sequence_number     (sequence_number),
    .timestamp_out       (timestamp_out),
    .marker_payload_type (marker_payload_type),
    .sequence_error      (sequence_error),
    .last                (last)
  );

endmodule
